@@ hw/rtl/bped_pkg.sv @@
// Shared types and constants for the button press event detector.
// No dependencies; every other file of the block but bped_ram uses this package.
`default_nettype none

package bped_pkg;

  localparam int CNT_W  = 16;
  localparam int IDX_W  = 3;
  localparam int CODE_W = 3;
  localparam int MASK_W = 8;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [CODE_W-1:0] code_t;

  localparam count_t CNT_MAX = '1;

  localparam code_t EV_CLICK_DOWN  = 3'd0;
  localparam code_t EV_HOLD        = 3'd1;
  localparam code_t EV_HOLD_REPEAT = 3'd2;
  localparam code_t EV_CLICK_UP    = 3'd3;
  localparam code_t EV_HOLD_UP     = 3'd4;

  localparam logic [1:0] REG_ACTIVE_LEVEL_MASK = 2'd0;
  localparam logic [1:0] REG_DOWN_TICKS        = 2'd1;
  localparam logic [1:0] REG_HOLD_TICKS        = 2'd2;
  localparam logic [1:0] REG_REPEAT_TICKS      = 2'd3;

  localparam logic [MASK_W-1:0] RST_ACTIVE_LEVEL_MASK = 8'd0;
  localparam count_t            RST_DOWN_TICKS        = 16'd2;
  localparam count_t            RST_HOLD_TICKS        = 16'd100;
  localparam count_t            RST_REPEAT_TICKS      = 16'd0;

endpackage

`default_nettype wire

@@ hw/rtl/bped_if.sv @@
// Valid/ready channel interfaces of the button press event detector:
// the sample channel in and the event channel out. Depends on bped_pkg.
`default_nettype none

interface bped_sample_if;
  logic                       valid;
  logic                       ready;
  logic [bped_pkg::IDX_W-1:0] button_index;
  logic                       pin_level;

  modport source (output valid, output button_index, output pin_level, input ready);
  modport sink (input valid, input button_index, input pin_level, output ready);
endinterface

interface bped_event_if;
  logic                        valid;
  logic                        ready;
  logic [bped_pkg::IDX_W-1:0]  event_button;
  logic [bped_pkg::CODE_W-1:0] event_code;

  modport source (output valid, output event_button, output event_code, input ready);
  modport sink (input valid, input event_button, input event_code, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bped_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bped_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bped_mod.sv @@
// Iterative restoring remainder unit: one quotient bit per cycle.
// Depends on bped_pkg for the counter width.
`default_nettype none

module bped_mod (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire bped_pkg::count_t dividend,
  input  wire bped_pkg::count_t divisor,
  output logic                  done,
  output bped_pkg::count_t      remainder
);
  import bped_pkg::*;

  localparam int STEP_W = (CNT_W > 1) ? $clog2(CNT_W) : 1;

  logic              busy;
  logic [STEP_W-1:0] step;
  count_t            dvd;
  count_t            dsr;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  assign trial = {remainder, dvd[CNT_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step      <= '0;
        dvd       <= dividend;
        dsr       <= divisor;
        remainder <= '0;
      end else if (busy) begin
        // keep the partial remainder below the divisor
        remainder <= diff[CNT_W] ? trial[CNT_W-1:0] : diff[CNT_W-1:0];
        dvd       <= {dvd[CNT_W-2:0], 1'b0};
        step      <= step + 1'b1;
        if (step == STEP_W'(CNT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/button_press_event_detector.sv @@
// Button press event detector: takes one scan-tick sample per transaction
// (button index and raw pin level) and raises click-down, hold, hold-repeat,
// click-up and hold-up events. The per-button press counters sit in a small
// RAM with registered read data; a valid bit per button makes every
// counter read as zero after reset, so no clearing pass is needed. A sample
// is read, updated and written back before the next one is taken, so samples
// are handled one at a time, and a held button past the hold threshold may
// need the hold-repeat check, which runs on the bit-serial remainder unit.
// A finished event waits in an output register, and new samples are taken
// while it waits; a second event stalls the sample channel until it drains.
// Samples for buttons at or beyond NUM_BUTTONS are taken and dropped.
// Registers (APB, 4-byte stride): 0 active_level_mask, 1 down_ticks,
// 2 hold_ticks, 3 repeat_ticks (0 disables hold-repeat events).
// Depends on bped_pkg, bped_if, bped_ram and bped_mod.
`default_nettype none

module button_press_event_detector #(
  parameter int NUM_BUTTONS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  bped_sample_if.sink                        button_sample,
  bped_event_if.source                       button_event,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bped_pkg::APB_AW-1:0]   paddr,
  input  wire logic [bped_pkg::APB_DW-1:0]   pwdata,
  output logic      [bped_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);
  import bped_pkg::*;

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MOD,
    S_EMIT
  } state_t;

  // configuration
  logic [MASK_W-1:0] active_level_mask;
  count_t            down_ticks;
  count_t            hold_ticks;
  count_t            repeat_ticks;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level_mask <= RST_ACTIVE_LEVEL_MASK;
      down_ticks        <= RST_DOWN_TICKS;
      hold_ticks        <= RST_HOLD_TICKS;
      repeat_ticks      <= RST_REPEAT_TICKS;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ACTIVE_LEVEL_MASK: active_level_mask <= pwdata[MASK_W-1:0];
        REG_DOWN_TICKS:        down_ticks        <= pwdata[CNT_W-1:0];
        REG_HOLD_TICKS:        hold_ticks        <= pwdata[CNT_W-1:0];
        REG_REPEAT_TICKS:      repeat_ticks      <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ACTIVE_LEVEL_MASK: prdata = APB_DW'(active_level_mask);
      REG_DOWN_TICKS:        prdata = APB_DW'(down_ticks);
      REG_HOLD_TICKS:        prdata = APB_DW'(hold_ticks);
      REG_REPEAT_TICKS:      prdata = APB_DW'(repeat_ticks);
      default:               prdata = '0;
    endcase
  end

  // sample path
  state_t                  state;
  logic [IDX_W-1:0]        idx_q;
  logic [AW-1:0]           addr_q;
  logic                    pressed_q;
  code_t                   code_q;
  logic [NUM_BUTTONS-1:0]  cnt_valid;
  logic                    out_valid;
  logic [IDX_W-1:0]        out_button;
  code_t                   out_code;

  logic                    sample_take;
  logic                    in_range;
  logic [31:0]             idx_ext;
  logic [AW-1:0]           sample_addr;
  count_t                  rdata;
  count_t                  old_cnt;
  count_t                  cnt_inc;
  logic                    at_max;
  logic                    ram_we;
  count_t                  ram_wdata;
  logic                    repeat_check;
  logic                    mod_done;
  count_t                  mod_rem;
  logic                    emit_load;

  assign button_sample.ready = (state == S_IDLE);
  assign sample_take         = button_sample.valid && button_sample.ready;
  assign idx_ext             = 32'(button_sample.button_index);
  assign in_range            = (idx_ext < 32'(NUM_BUTTONS));
  assign sample_addr         = idx_ext[AW-1:0];

  assign old_cnt = cnt_valid[addr_q] ? rdata : '0;
  assign cnt_inc = old_cnt + 1'b1;
  assign at_max  = (old_cnt == CNT_MAX);

  assign ram_we    = (state == S_READ) && !(pressed_q && at_max);
  assign ram_wdata = pressed_q ? cnt_inc : '0;

  assign repeat_check = (state == S_READ) && pressed_q && !at_max
                        && (cnt_inc != down_ticks) && (cnt_inc != hold_ticks)
                        && (cnt_inc > hold_ticks) && (repeat_ticks != '0);

  // load the output register once it is free or draining this cycle
  assign emit_load = (state == S_EMIT) && (!out_valid || button_event.ready);

  bped_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BUTTONS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (ram_wdata),
    .re    (sample_take),
    .raddr (sample_addr),
    .rdata (rdata)
  );

  bped_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (repeat_check),
    .dividend  (cnt_inc),
    .divisor   (repeat_ticks),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (button_event.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // drop samples for buttons that do not exist
          if (sample_take && in_range) begin
            idx_q     <= button_sample.button_index;
            addr_q    <= sample_addr;
            pressed_q <= (button_sample.pin_level
                          == active_level_mask[button_sample.button_index]);
            state     <= S_READ;
          end
        end
        S_READ: begin
          state <= S_IDLE;
          if (pressed_q) begin
            if (!at_max) begin
              cnt_valid[addr_q] <= 1'b1;
              if (cnt_inc == down_ticks) begin
                code_q <= EV_CLICK_DOWN;
                state  <= S_EMIT;
              end else if (cnt_inc == hold_ticks) begin
                code_q <= EV_HOLD;
                state  <= S_EMIT;
              end else if (repeat_check) begin
                state <= S_MOD;
              end
            end
          end else begin
            cnt_valid[addr_q] <= 1'b1;
            if (old_cnt >= down_ticks && old_cnt < hold_ticks) begin
              code_q <= EV_CLICK_UP;
              state  <= S_EMIT;
            end else if (old_cnt >= hold_ticks) begin
              code_q <= EV_HOLD_UP;
              state  <= S_EMIT;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            if (mod_rem == '0) begin
              code_q <= EV_HOLD_REPEAT;
              state  <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (emit_load) begin
            out_button <= idx_q;
            out_code   <= code_q;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign button_event.valid        = out_valid;
  assign button_event.event_button = out_button;
  assign button_event.event_code   = out_code;

endmodule

`default_nettype wire

@@ bench/button_event_checker.sv @@
// Event checker for the button press event detector: snoops the sample channel,
// the event channel and APB register writes, and predicts and compares events.
// Depends on bped_pkg and bped_if.
`timescale 1ns / 100ps

module button_event_checker #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  bped_sample_if                        smp,
  bped_event_if                         evt,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [bped_pkg::APB_AW-1:0]   paddr,
  input  logic [bped_pkg::APB_DW-1:0]   pwdata,
  output int                            errors,
  output int                            pending
);
  import bped_pkg::*;

  typedef struct packed {
    logic  fire;
    code_t code;
  } press_result_t;

  typedef struct packed {
    logic [IDX_W-1:0] button;
    code_t            code;
  } button_event_t;

  logic [MASK_W-1:0] level_mask;
  count_t            down_thr;
  count_t            hold_thr;
  count_t            repeat_per;
  count_t            press_cnt [NUM_BUTTONS];
  button_event_t     expected_events [$];
  int                fail_total = 0;

  // Advance one button's press counter and return the event it raises, if any.
  function automatic press_result_t advance_press(input logic [IDX_W-1:0] idx,
                                                  input logic lvl);
    press_result_t  res;
    count_t         old;
    logic [CNT_W:0] cnt;
    res.fire = 1'b0;
    res.code = EV_CLICK_DOWN;
    if (idx < NUM_BUTTONS) begin
      old = press_cnt[idx];
      if (lvl == level_mask[idx]) begin
        // a saturated counter stays put and stays silent
        if (old != CNT_MAX) begin
          cnt = {1'b0, old} + 1'b1;
          press_cnt[idx] = cnt[CNT_W-1:0];
          if (cnt == down_thr) begin
            res.fire = 1'b1;
            res.code = EV_CLICK_DOWN;
          end else if (cnt == hold_thr) begin
            res.fire = 1'b1;
            res.code = EV_HOLD;
          end else if (cnt > hold_thr && repeat_per != 0 && cnt % repeat_per == 0) begin
            res.fire = 1'b1;
            res.code = EV_HOLD_REPEAT;
          end
        end
      end else begin
        press_cnt[idx] = '0;
        if (old >= down_thr && old < hold_thr) begin
          res.fire = 1'b1;
          res.code = EV_CLICK_UP;
        end else if (old >= hold_thr) begin
          res.fire = 1'b1;
          res.code = EV_HOLD_UP;
        end
      end
    end
    return res;
  endfunction

  task automatic note_failure(input string msg);
    fail_total++;
    if (fail_total <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    button_event_t want;
    press_result_t res;
    if (rst) begin
      level_mask = RST_ACTIVE_LEVEL_MASK;
      down_thr   = RST_DOWN_TICKS;
      hold_thr   = RST_HOLD_TICKS;
      repeat_per = RST_REPEAT_TICKS;
      for (int b = 0; b < NUM_BUTTONS; b++) press_cnt[b] = '0;
      expected_events.delete();
    end else begin
      // compare before predicting, so a stray event is never matched against
      // an expectation created in the same cycle
      if (evt.valid && evt.ready) begin
        if (expected_events.size() == 0) begin
          note_failure($sformatf("unexpected event: button %0d code %0d",
                                 evt.event_button, evt.event_code));
        end else begin
          want = expected_events.pop_front();
          if (evt.event_button !== want.button || evt.event_code !== want.code)
            note_failure($sformatf("event mismatch: button %0d code %0d, expected %0d / %0d",
                                   evt.event_button, evt.event_code, want.button, want.code));
        end
      end
      if (smp.valid && smp.ready) begin
        res = advance_press(smp.button_index, smp.pin_level);
        if (res.fire) expected_events.push_back('{smp.button_index, res.code});
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ACTIVE_LEVEL_MASK: level_mask = pwdata[MASK_W-1:0];
          REG_DOWN_TICKS:        down_thr   = pwdata[CNT_W-1:0];
          REG_HOLD_TICKS:        hold_thr   = pwdata[CNT_W-1:0];
          REG_REPEAT_TICKS:      repeat_per = pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= expected_events.size();
    errors  <= fail_total;
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the button press event detector bench: clock, reset, sample and APB
// stimulus, event backpressure and the verdict. Depends on bped_pkg, bped_if,
// button_event_checker and the detector RTL.
`timescale 1ns / 100ps

module tb_top;
  import bped_pkg::*;

  localparam int NUM_BUTTONS   = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 6000000;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              evt_ready = 1'b0;
  int                fail_count;
  int                pending_events;

  // stimulus-side copy of the settings, used only to shape press runs
  logic [MASK_W-1:0] cfg_mask = RST_ACTIVE_LEVEL_MASK;
  count_t            cfg_down = RST_DOWN_TICKS;
  count_t            cfg_hold = RST_HOLD_TICKS;
  count_t            cfg_rep  = RST_REPEAT_TICKS;

  bit calm       = 1'b0;
  bit ready_calm = 1'b0;
  int stall_left = 0;

  bped_sample_if smp_if ();
  bped_event_if  evt_if ();

  assign evt_if.ready = evt_ready;

  button_press_event_detector #(.NUM_BUTTONS(NUM_BUTTONS)) u_top (
    .clk           (clk),
    .rst           (rst),
    .button_sample (smp_if),
    .button_event  (evt_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  button_event_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_checker (
    .clk     (clk),
    .rst     (rst),
    .smp     (smp_if),
    .evt     (evt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (fail_count),
    .pending (pending_events)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 255) == 0) ready_calm = !ready_calm;
    if (rst) begin
      evt_ready  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      evt_ready <= 1'b0;
      stall_left--;
    end else if (!ready_calm && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      evt_ready <= (stall_left == 0);
    end else begin
      evt_ready <= 1'b1;
    end
  end

  // Returns right after the edge at which the transaction was accepted,
  // with valid still high.
  task automatic send_sample(input logic [IDX_W-1:0] idx, input logic lvl);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_if.valid        <= 1'b1;
    smp_if.button_index <= idx;
    smp_if.pin_level    <= lvl;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
  endtask

  task automatic hold_button(input logic [IDX_W-1:0] idx, input int n);
    repeat (n) send_sample(idx, cfg_mask[idx]);
  endtask

  task automatic let_go(input logic [IDX_W-1:0] idx);
    send_sample(idx, !cfg_mask[idx]);
  endtask

  // Drop valid, wait for every expected event, then cover a silent sample
  // still in flight.
  task automatic settle();
    smp_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_config(input logic [MASK_W-1:0] mask, input count_t down,
                              input count_t hold, input count_t rep);
    logic [APB_DW-1:0] junk;
    settle();
    // upper bits carry noise; the registers must ignore them
    junk = $urandom;
    write_reg(REG_ACTIVE_LEVEL_MASK, {junk[31:8], mask});
    write_reg(REG_DOWN_TICKS, {junk[15:0], down});
    write_reg(REG_HOLD_TICKS, {junk[31:16], hold});
    write_reg(REG_REPEAT_TICKS, {junk[23:8], rep});
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_mask = mask;
    cfg_down = down;
    cfg_hold = hold;
    cfg_rep  = rep;
  endtask

  // Mostly press runs around the thresholds ending in a release, plus
  // stray samples and runs that never get released.
  task automatic random_phase(input logic [MASK_W-1:0] mask, input count_t down,
                              input count_t hold, input count_t rep, input int budget);
    int               sent;
    int               len;
    int               span;
    logic [IDX_W-1:0] idx;
    apply_config(mask, down, hold, rep);
    sent = 0;
    while (sent < budget) begin
      calm = ($urandom_range(0, 3) == 0);
      idx  = IDX_W'($urandom_range(0, NUM_BUTTONS - 1));
      if ($urandom_range(0, 3) == 0) begin
        send_sample(idx, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        span = cfg_hold + 3 * cfg_rep + 3;
        if (span > 40) span = 40;
        len = $urandom_range(0, span);
        hold_button(idx, len);
        sent += len;
        if ($urandom_range(0, 9) != 0) begin
          let_go(idx);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    smp_if.valid        <= 1'b0;
    smp_if.button_index <= '0;
    smp_if.pin_level    <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: click-down at two ticks, click-up, release of an idle button
    hold_button(0, 2);
    let_go(0);
    let_go(7);
    // click-down, hold, repeats, hold-up; click-down then click-up
    apply_config(8'hA5, 16'd1, 16'd3, 16'd2);
    hold_button(5, 6);
    let_go(5);
    hold_button(1, 2);
    let_go(1);
    // zero down threshold: releasing an idle button gives click-up
    apply_config(8'h00, 16'd0, 16'd2, 16'd1);
    let_go(3);
    hold_button(3, 3);
    let_go(3);
    // equal thresholds: only click-down on the press
    apply_config(8'hFF, 16'd2, 16'd2, 16'd0);
    hold_button(6, 2);
    let_go(6);

    // long press past the hold threshold with back-to-back repeat checks
    apply_config(8'h5A, 16'd1, 16'd30, 16'd7);
    calm = 1'b1;
    hold_button(2, 60);
    let_go(2);

    random_phase(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 60);
    random_phase(8'h00, 16'd0, 16'd0, 16'd0, 120);
    random_phase(MASK_W'($urandom), 16'd5, 16'd3, 16'd1, 130);
    random_phase(MASK_W'($urandom), 16'd1, 16'd1, 16'd2, 120);
    repeat (7) begin
      count_t down;
      down = count_t'($urandom_range(1, 6));
      random_phase(MASK_W'($urandom), down, count_t'(down + $urandom_range(1, 20)),
                   count_t'($urandom_range(0, 5)), 130);
    end

    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bped_pkg.sv
hw/rtl/bped_if.sv
hw/rtl/bped_ram.sv
hw/rtl/bped_mod.sv
hw/rtl/button_press_event_detector.sv
bench/button_event_checker.sv
bench/tb_top.sv
